>>> rtl/term_frequency_histogram_assert.svh
// assertion macros for the term frequency histogram
`ifndef TERM_FREQUENCY_HISTOGRAM_ASSERT_SVH
`define TERM_FREQUENCY_HISTOGRAM_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TFH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define TFH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tfh_pkg.sv
package tfh_pkg;

  localparam int TERM_SPACE_DEF = 4096;
  localparam int COUNT_BITS_DEF = 16;

  localparam int OPCODE_W   = 2;
  localparam int TERM_ID_W  = 12;
  localparam int TOTAL_W    = 16;
  localparam int DISTINCT_W = 13;
  localparam int FREQ_W     = 16;

  localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = '1;
  localparam logic [DISTINCT_W-1:0] DISTINCT_MAX = '1;
  localparam logic [FREQ_W-1:0]     FREQ_MAX     = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_COUNT  = 2'd0,
    OP_REPORT = 2'd1,
    OP_DRAIN  = 2'd2
  } tfh_op_t;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_PAIR    = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_SCAN_FIRST,
    ST_SCAN_NEXT,
    ST_EMIT
  } tfh_state_t;

  typedef struct packed {
    logic                  kind;
    logic [TOTAL_W-1:0]    total_terms;
    logic [DISTINCT_W-1:0] distinct_terms;
    logic [TERM_ID_W-1:0]  pair_term;
    logic [FREQ_W-1:0]     frequency;
    logic                  last_pair;
    logic                  empty_res;
  } tfh_res_t;

  typedef struct packed {
    logic clearing;
    logic scanning;
  } tfh_stat_t;

endpackage

>>> rtl/tfh_ifs.sv
interface tfh_item_if;
  import tfh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [TERM_ID_W-1:0] term_id;

  modport source (output valid, output opcode, output term_id, input ready);
  modport sink (input valid, input opcode, input term_id, output ready);
endinterface

interface tfh_result_if;
  import tfh_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [TOTAL_W-1:0]    total_terms;
  logic [DISTINCT_W-1:0] distinct_terms;
  logic [TERM_ID_W-1:0]  pair_term;
  logic [FREQ_W-1:0]     frequency;
  logic                  last_pair;
  logic                  empty_res;

  modport source (output valid, output kind, output total_terms, output distinct_terms,
                  output pair_term, output frequency, output last_pair, output empty_res,
                  input ready);
  modport sink (input valid, input kind, input total_terms, input distinct_terms,
                input pair_term, input frequency, input last_pair, input empty_res,
                output ready);
endinterface

>>> rtl/tfh_ram.sv
module tfh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tfh_core.sv
module tfh_core #(
  parameter int TERM_SPACE = tfh_pkg::TERM_SPACE_DEF,
  parameter int COUNT_BITS = tfh_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tfh_pkg::OPCODE_W-1:0]   opcode,
  input  logic [tfh_pkg::TERM_ID_W-1:0]  term_id,
  output logic                           res_valid,
  input  logic                           res_take,
  output tfh_pkg::tfh_res_t              res,
  output tfh_pkg::tfh_stat_t             stat
);
  import tfh_pkg::*;

  localparam int ID_W  = $clog2(TERM_SPACE);
  localparam int PTR_W = ID_W + 1;
  localparam int CW    = COUNT_BITS;
  localparam int CMP_W = (PTR_W > TERM_ID_W + 1) ? PTR_W : TERM_ID_W + 1;

  localparam logic [ID_W-1:0]  LAST_ADDR = ID_W'(TERM_SPACE - 1);
  localparam logic [PTR_W-1:0] END_PTR   = PTR_W'(TERM_SPACE);
  localparam logic [CW-1:0]    CNT_MAX   = '1;

  tfh_state_t state, state_next;

  logic [ID_W-1:0]       clr_addr, clr_addr_next;
  logic [ID_W-1:0]       cnt_addr, cnt_addr_next;
  // every id below low_ptr (other than zero) has a zero counter
  logic [PTR_W-1:0]      low_ptr, low_ptr_next;
  logic [PTR_W-1:0]      issue_addr, issue_addr_next;
  logic                  chk_valid, chk_valid_next;
  logic [ID_W-1:0]       chk_addr, chk_addr_next;
  logic [ID_W-1:0]       found_addr, found_addr_next;
  logic [CW-1:0]         found_freq, found_freq_next;
  logic [TOTAL_W-1:0]    total_cnt, total_cnt_next;
  logic [DISTINCT_W-1:0] distinct_cnt, distinct_cnt_next;
  tfh_res_t              res_next;

  logic            mem_we;
  logic [ID_W-1:0] mem_waddr;
  logic [CW-1:0]   mem_wdata;
  logic [ID_W-1:0] mem_raddr;
  logic [CW-1:0]   mem_rdata;

  logic [ID_W-1:0]   id_addr;
  logic              id_ok;
  logic              hit;
  logic              exhausted;
  logic              leave;
  logic              issue;
  logic [FREQ_W-1:0] freq_out;

  tfh_ram #(
    .WIDTH (CW),
    .DEPTH (TERM_SPACE)
  ) u_count_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign id_addr = ID_W'(term_id);
  assign id_ok   = (term_id != '0) && (CMP_W'(term_id) < CMP_W'(TERM_SPACE));

  assign hit       = chk_valid && (mem_rdata != '0);
  assign exhausted = !chk_valid && (issue_addr >= END_PTR);
  assign freq_out  = (found_freq > CW'(FREQ_MAX)) ? FREQ_MAX : FREQ_W'(found_freq);

  assign stat.clearing = (state == ST_CLEAR);
  assign stat.scanning = (state == ST_SCAN_FIRST) || (state == ST_SCAN_NEXT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      low_ptr      <= END_PTR;
      chk_valid    <= 1'b0;
      total_cnt    <= '0;
      distinct_cnt <= '0;
    end else begin
      state        <= state_next;
      clr_addr     <= clr_addr_next;
      low_ptr      <= low_ptr_next;
      chk_valid    <= chk_valid_next;
      total_cnt    <= total_cnt_next;
      distinct_cnt <= distinct_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt_addr   <= cnt_addr_next;
    issue_addr <= issue_addr_next;
    chk_addr   <= chk_addr_next;
    found_addr <= found_addr_next;
    found_freq <= found_freq_next;
    res        <= res_next;
  end

  always_comb begin
    state_next        = state;
    clr_addr_next     = clr_addr;
    cnt_addr_next     = cnt_addr;
    low_ptr_next      = low_ptr;
    issue_addr_next   = issue_addr;
    chk_valid_next    = 1'b0;
    chk_addr_next     = issue_addr[ID_W-1:0];
    found_addr_next   = found_addr;
    found_freq_next   = found_freq;
    total_cnt_next    = total_cnt;
    distinct_cnt_next = distinct_cnt;
    res_next          = res;
    in_ready          = 1'b0;
    res_valid         = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = cnt_addr;
    mem_wdata         = '0;
    mem_raddr         = id_addr;
    leave             = 1'b0;
    issue             = 1'b0;

    case (state)
      ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        clr_addr_next = clr_addr + ID_W'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (opcode)
            OP_COUNT: begin
              if (id_ok) begin
                cnt_addr_next = id_addr;
                state_next    = ST_COUNT;
              end
            end
            OP_REPORT: begin
              res_next                = '0;
              res_next.kind           = KIND_SUMMARY;
              res_next.total_terms    = total_cnt;
              res_next.distinct_terms = distinct_cnt;
              res_next.empty_res      = (distinct_cnt == '0);
              total_cnt_next          = '0;
              distinct_cnt_next       = '0;
              state_next              = ST_EMIT;
            end
            OP_DRAIN: begin
              issue_addr_next = low_ptr;
              state_next      = ST_SCAN_FIRST;
            end
            default: begin
            end
          endcase
        end
      end

      // read data of the counter arrives now; write back the increment, saturating at the counter maximum
      ST_COUNT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_addr;
        mem_wdata = (mem_rdata == CNT_MAX) ? mem_rdata : mem_rdata + CW'(1);
        if ((mem_rdata == '0) && (distinct_cnt != DISTINCT_MAX)) begin
          distinct_cnt_next = distinct_cnt + DISTINCT_W'(1);
        end
        if (total_cnt != TOTAL_MAX) begin
          total_cnt_next = total_cnt + TOTAL_W'(1);
        end
        if (PTR_W'(cnt_addr) < low_ptr) begin
          low_ptr_next = PTR_W'(cnt_addr);
        end
        state_next = ST_IDLE;
      end

      // one read issued per cycle, checked in the next cycle
      ST_SCAN_FIRST, ST_SCAN_NEXT: begin
        mem_raddr       = issue_addr[ID_W-1:0];
        leave           = ((state == ST_SCAN_NEXT) && hit) || exhausted;
        issue           = !leave && (issue_addr < END_PTR);
        chk_valid_next  = issue;
        issue_addr_next = issue_addr + PTR_W'(issue);
        if (state == ST_SCAN_FIRST) begin
          if (hit) begin
            mem_we          = 1'b1;
            mem_waddr       = chk_addr;
            found_addr_next = chk_addr;
            found_freq_next = mem_rdata;
            state_next      = ST_SCAN_NEXT;
          end else if (exhausted) begin
            res_next           = '0;
            res_next.kind      = KIND_PAIR;
            res_next.empty_res = 1'b1;
            low_ptr_next       = END_PTR;
            state_next         = ST_EMIT;
          end
        end else if (leave) begin
          res_next           = '0;
          res_next.kind      = KIND_PAIR;
          res_next.pair_term = TERM_ID_W'(found_addr);
          res_next.frequency = freq_out;
          res_next.last_pair = !hit;
          low_ptr_next       = hit ? PTR_W'(chk_addr) : END_PTR;
          state_next         = ST_EMIT;
        end
      end

      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/term_frequency_histogram.sv
// count item: a read of the counter memory, then the write back of the increment
// report item: the summary is registered in the core, then moved to the output register
// drain item: entries are scanned one a cycle from the lowest possibly nonzero id to the next
//   nonzero one past the drained pair, or to the top of the term space
// one item at a time; one result waiting in the output register does not hold off the next item
// rst (synchronous) clears control state, then every counter is cleared in turn, no item taken
`include "term_frequency_histogram_assert.svh"

module term_frequency_histogram #(
  parameter int TERM_SPACE = tfh_pkg::TERM_SPACE_DEF,
  parameter int COUNT_BITS = tfh_pkg::COUNT_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  tfh_item_if.sink     item,
  tfh_result_if.source result
);
  import tfh_pkg::*;

  logic      res_valid;
  logic      res_take;
  tfh_res_t  res;
  tfh_stat_t stat;
  logic      out_valid;
  tfh_res_t  out_res;

  tfh_core #(
    .TERM_SPACE (TERM_SPACE),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .opcode    (item.opcode),
    .term_id   (item.term_id),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .stat      (stat)
  );

  // output slot is free when empty or emptied this cycle
  assign res_take = res_valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.kind           = out_res.kind;
  assign result.total_terms    = out_res.total_terms;
  assign result.distinct_terms = out_res.distinct_terms;
  assign result.pair_term      = out_res.pair_term;
  assign result.frequency      = out_res.frequency;
  assign result.last_pair      = out_res.last_pair;
  assign result.empty_res      = out_res.empty_res;

  `TFH_ASSERT_NEXT(a_res_held, res_valid && !res_take, res_valid && $stable(res), "core result changed before transfer")
  `TFH_ASSERT_NOW(a_busy_no_take, stat.clearing || stat.scanning, !item.ready, "item taken while clearing or scanning")
  `TFH_ASSERT_NEXT(a_res_loaded, res_take, result.valid, "transferred result not shown on output")

endmodule
